### rtl/core/iopra_pkg.sv
package iopra_pkg;

    localparam int TableEntries = 32;
    localparam int IdxW = $clog2(TableEntries);
    localparam int CntW = $clog2(TableEntries + 1);
    localparam logic [16:0] PortSpace = 17'h10000;

    typedef enum logic [1:0] {
        KIND_FIXED = 2'd0,
        KIND_ANY   = 2'd1,
        KIND_FREE  = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_SEARCH_BASE  = 2'd0,
        CFG_SEARCH_LIMIT = 2'd1,
        CFG_SPACE_TOP    = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALIGN,
        S_WALK,
        S_DECIDE,
        S_SHIFT,
        S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } op_t;

    // Command from the controller to the cell row.
    typedef struct packed {
        op_t         op;
        logic [IdxW-1:0] pos;
        logic [15:0] start;
        logic [16:0] stop;
    } row_cmd_t;

    typedef struct packed {
        logic [15:0] start;
        logic [16:0] stop;
    } entry_t;

endpackage

### rtl/core/iopra_if.sv
interface iopra_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] port;
    logic [16:0] size;
    logic [12:0] align;
    modport source (output valid, kind, port, size, align, input ready);
    modport sink (input valid, kind, port, size, align, output ready);
endinterface

interface iopra_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] granted_port;
    modport source (output valid, status, granted_port, input ready);
    modport sink (input valid, status, granted_port, output ready);
endinterface

### rtl/core/iopra_cell.sv
// One table slot. Insert takes the left neighbor's entry when above the
// position; remove takes the right neighbor's entry from the position on.
module iopra_cell (
    input  logic                      clk,
    input  logic [iopra_pkg::IdxW-1:0] my_idx,
    input  iopra_pkg::row_cmd_t       cmd,
    input  iopra_pkg::entry_t         left,
    input  iopra_pkg::entry_t         right,
    output iopra_pkg::entry_t         entry
);
    iopra_pkg::entry_t entry_reg;
    iopra_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            iopra_pkg::OP_INSERT:
            begin
                if (my_idx == cmd.pos)
                begin
                    entry_next.start = cmd.start;
                    entry_next.stop  = cmd.stop;
                end
                else if (my_idx > cmd.pos)
                begin
                    entry_next = left;
                end
            end
            iopra_pkg::OP_REMOVE:
            begin
                if (my_idx >= cmd.pos)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
endmodule

### rtl/core/iopra_row.sv
// Row of cells; a read port returns the entry at the walk index.
module iopra_row (
    input  logic                       clk,
    input  iopra_pkg::row_cmd_t        cmd,
    input  logic [iopra_pkg::IdxW-1:0] rd_idx,
    output iopra_pkg::entry_t          rd_entry
);
    iopra_pkg::entry_t cells [iopra_pkg::TableEntries];

    for (genvar g = 0; g < iopra_pkg::TableEntries; g++)
    begin : g_cell
        iopra_pkg::entry_t l_in;
        iopra_pkg::entry_t r_in;
        if (g == 0)
        begin : g_first
            assign l_in = cells[0];
        end
        else
        begin : g_mid
            assign l_in = cells[g-1];
        end
        if (g == iopra_pkg::TableEntries - 1)
        begin : g_last
            assign r_in = cells[g];
        end
        else
        begin : g_rest
            assign r_in = cells[g+1];
        end
        iopra_cell u_cell (
            .clk    (clk),
            .my_idx (iopra_pkg::IdxW'(g)),
            .cmd    (cmd),
            .left   (l_in),
            .right  (r_in),
            .entry  (cells[g])
        );
    end

    assign rd_entry = cells[rd_idx];
endmodule

### rtl/core/iopra_align.sv
// Rounds a value up to a multiple of align, a bit each cycle (restoring
// division of value+align-1 by align, then multiply back).
module iopra_align (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [16:0] value,
    input  logic [12:0] align,
    output logic        busy,
    output logic [17:0] result
);
    logic [17:0] num_reg, num_next;
    logic [12:0] rem_reg, rem_next;
    logic [17:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic [12:0] a_reg, a_next;
    logic [13:0] trial;
    logic [30:0] prod;

    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        a_next   = a_reg;
        trial    = {rem_reg, num_reg[17]};
        if (start)
        begin
            a_next   = align;
            rem_next = '0;
            quo_next = '0;
            cnt_next = 5'd18;
            num_next = (align == '0) ? {1'b0, value}
                                     : {1'b0, value} + {5'd0, align} - 18'd1;
            run_next = (align != '0);
        end
        else if (run_reg)
        begin
            num_next = {num_reg[16:0], 1'b0};
            if (trial >= {1'b0, a_reg})
            begin
                rem_next = 13'(trial - {1'b0, a_reg});
                quo_next = {quo_reg[16:0], 1'b1};
            end
            else
            begin
                rem_next = trial[12:0];
                quo_next = {quo_reg[16:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        a_reg   <= a_next;
    end

    assign prod   = 31'(quo_reg) * 31'(a_reg);
    assign busy   = run_reg;
    // With no alignment num holds the value itself.
    assign result = (a_reg == '0) ? num_reg : (prod[30:18] != '0 ? 18'h3FFFF : prod[17:0]);
endmodule

### rtl/core/io_port_range_allocator.sv
// Channel | Dir | Fields
// req     | in  | kind, port, size, align
// rsp     | out | status, granted_port
// cfg     | in  | cfg_we, cfg_index, cfg_data
//
// One request at a time: the search base is aligned first, then a walk over
// the entries, one entry a cycle while no alignment is pending; for any-port
// requests each move of the candidate to an entry's end runs the bit-serial
// aligner again. Then come deciding, shifting the cell row (only when a range
// is added or removed), responding and returning to idle.
// Reset clears the entry count and the controller state and loads the configuration registers with their defaults.
// A stalled response holds the block; the next request waits for it.
module io_port_range_allocator (
    input  logic        clk,
    input  logic        rst_n,
    iopra_req_if.sink   req,
    iopra_rsp_if.source rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    localparam int IdxW = iopra_pkg::IdxW;
    localparam int CntW = iopra_pkg::CntW;

    iopra_pkg::state_t state_reg, state_next;
    logic [15:0] base_reg;
    logic [16:0] limit_reg, top_reg;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] idx_reg, idx_next;
    logic [1:0]  kind_reg;
    logic [15:0] port_reg;
    logic [16:0] size_reg;
    logic [12:0] align_reg;
    logic [17:0] cand_reg, cand_next;
    logic        found_reg, found_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] gport_reg, gport_next;
    iopra_pkg::row_cmd_t cmd;
    iopra_pkg::entry_t   rd;
    logic        al_start;
    logic [16:0] al_value;
    logic [12:0] al_align;
    logic        al_busy;
    logic [17:0] al_result;
    logic        al_wait_reg, al_wait_next;
    logic [16:0] lim_cap, top_cap;
    logic [17:0] pend;
    logic        full;

    assign lim_cap = (limit_reg > iopra_pkg::PortSpace) ? iopra_pkg::PortSpace : limit_reg;
    assign top_cap = (top_reg > iopra_pkg::PortSpace) ? iopra_pkg::PortSpace : top_reg;
    assign pend    = {2'd0, port_reg} + {1'b0, size_reg};
    assign full    = (count_reg == CntW'(iopra_pkg::TableEntries));

    // The first alignment starts while the request is being accepted.
    assign al_align = (state_reg == iopra_pkg::S_IDLE) ? req.align : align_reg;

    iopra_row u_row (
        .clk      (clk),
        .cmd      (cmd),
        .rd_idx   (idx_reg[IdxW-1:0]),
        .rd_entry (rd)
    );

    iopra_align u_align (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (al_start),
        .value  (al_value),
        .align  (al_align),
        .busy   (al_busy),
        .result (al_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= 16'd1024;
            limit_reg <= 17'd4096;
            top_reg   <= 17'h10000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                iopra_pkg::CFG_SEARCH_BASE:  base_reg  <= cfg_data[15:0];
                iopra_pkg::CFG_SEARCH_LIMIT: limit_reg <= cfg_data;
                iopra_pkg::CFG_SPACE_TOP:    top_reg   <= cfg_data;
                default:                     base_reg  <= base_reg;
            endcase
        end
    end

    // Walk step: for an any-port request the aligner is started whenever the
    // candidate must move to an entry's end; the walk resumes once it is idle again.
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cand_next    = cand_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        gport_next   = gport_reg;
        count_next   = count_reg;
        al_wait_next = al_wait_reg;
        al_start     = 1'b0;
        al_value     = {1'b0, base_reg};
        case (state_reg)
            iopra_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = iopra_pkg::S_ALIGN;
                    idx_next   = '0;
                    found_next = 1'b0;
                    al_start   = 1'b1;
                    al_wait_next = 1'b1;
                end
            end
            iopra_pkg::S_ALIGN:
            begin
                al_value = {1'b0, base_reg};
                if (!al_busy && al_wait_reg)
                begin
                    cand_next    = al_result;
                    al_wait_next = 1'b0;
                    state_next   = iopra_pkg::S_WALK;
                end
            end
            iopra_pkg::S_WALK:
            begin
                al_value = rd.stop;
                if (al_wait_reg)
                begin
                    if (!al_busy)
                    begin
                        cand_next    = al_result;
                        al_wait_next = 1'b0;
                        idx_next     = idx_reg + CntW'(1);
                    end
                end
                else if (idx_reg >= count_reg)
                begin
                    state_next = iopra_pkg::S_DECIDE;
                end
                else
                begin
                    case (kind_reg)
                        iopra_pkg::KIND_FIXED:
                        begin
                            if ({1'b0, rd.stop} <= {2'd0, port_reg})
                            begin
                                idx_next = idx_reg + CntW'(1);
                            end
                            else
                            begin
                                found_next = ({2'd0, rd.start} < pend);
                                state_next = iopra_pkg::S_DECIDE;
                            end
                        end
                        iopra_pkg::KIND_ANY:
                        begin
                            if (rd.start < base_reg)
                            begin
                                if ({1'b0, rd.stop} > cand_reg)
                                begin
                                    al_start     = 1'b1;
                                    al_wait_next = 1'b1;
                                end
                                else
                                begin
                                    idx_next = idx_reg + CntW'(1);
                                end
                            end
                            else if ({2'd0, rd.start} > cand_reg &&
                                     {2'd0, rd.start} - cand_reg > {1'b0, size_reg})
                            begin
                                state_next = iopra_pkg::S_DECIDE;
                            end
                            else
                            begin
                                al_start     = 1'b1;
                                al_wait_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (rd.start == port_reg)
                            begin
                                found_next = 1'b1;
                                state_next = iopra_pkg::S_DECIDE;
                            end
                            else if (rd.start > port_reg)
                            begin
                                state_next = iopra_pkg::S_DECIDE;
                            end
                            else
                            begin
                                idx_next = idx_reg + CntW'(1);
                            end
                        end
                    endcase
                end
            end
            iopra_pkg::S_DECIDE:
            begin
                state_next  = iopra_pkg::S_RESULT;
                status_next = iopra_pkg::ST_REFUSED;
                gport_next  = '0;
                case (kind_reg)
                    iopra_pkg::KIND_FIXED:
                    begin
                        if (pend <= {1'b0, top_cap} && !found_reg)
                        begin
                            status_next = full ? iopra_pkg::ST_FULL : iopra_pkg::ST_DONE;
                            gport_next  = port_reg;
                            if (!full)
                            begin
                                state_next = iopra_pkg::S_SHIFT;
                            end
                        end
                    end
                    iopra_pkg::KIND_ANY:
                    begin
                        if (cand_reg < {1'b0, iopra_pkg::PortSpace} &&
                            cand_reg + {1'b0, size_reg} <= {1'b0, lim_cap})
                        begin
                            status_next = full ? iopra_pkg::ST_FULL : iopra_pkg::ST_DONE;
                            gport_next  = cand_reg[15:0];
                            if (!full)
                            begin
                                state_next = iopra_pkg::S_SHIFT;
                            end
                        end
                    end
                    iopra_pkg::KIND_FREE:
                    begin
                        if (found_reg)
                        begin
                            status_next = iopra_pkg::ST_DONE;
                            gport_next  = port_reg;
                            state_next  = iopra_pkg::S_SHIFT;
                        end
                    end
                    default:
                    begin
                        state_next = iopra_pkg::S_RESULT;
                    end
                endcase
            end
            iopra_pkg::S_SHIFT:
            begin
                count_next = (kind_reg == iopra_pkg::KIND_FREE) ? count_reg - CntW'(1)
                                                               : count_reg + CntW'(1);
                state_next = iopra_pkg::S_RESULT;
            end
            iopra_pkg::S_RESULT:
            begin
                if (rsp.ready)
                begin
                    state_next = iopra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = iopra_pkg::S_IDLE;
            end
        endcase
    end

    // Row command: only in the shift state.
    always_comb
    begin
        cmd.op    = iopra_pkg::OP_HOLD;
        cmd.pos   = idx_reg[IdxW-1:0];
        cmd.start = gport_reg;
        cmd.stop  = 17'({1'b0, gport_reg} + size_reg);
        if (state_reg == iopra_pkg::S_SHIFT)
        begin
            cmd.op = (kind_reg == iopra_pkg::KIND_FREE) ? iopra_pkg::OP_REMOVE
                                                       : iopra_pkg::OP_INSERT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= iopra_pkg::S_IDLE;
            count_reg   <= '0;
            al_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            al_wait_reg <= al_wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cand_reg   <= cand_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        gport_reg  <= gport_next;
        if (state_reg == iopra_pkg::S_IDLE && req.valid)
        begin
            kind_reg  <= req.kind;
            port_reg  <= req.port;
            size_reg  <= req.size;
            align_reg <= req.align;
        end
    end

    assign req.ready        = (state_reg == iopra_pkg::S_IDLE);
    assign rsp.valid        = (state_reg == iopra_pkg::S_RESULT);
    assign rsp.status       = status_reg;
    assign rsp.granted_port = gport_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(iopra_pkg::TableEntries))
        else $error("entry count above table size");
    a_shift_changes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == iopra_pkg::S_SHIFT |=> count_reg != $past(count_reg))
        else $error("shift did not change entry count");
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == iopra_pkg::S_IDLE |=> $stable(count_reg))
        else $error("entry count moved outside a shift");
endmodule

### verif/testbench.sv
module testbench;
    import iopra_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Slots = 32;
    localparam int DrainCycles = 1000;
    localparam longint CycleLimit = 8000000;

    // Mirrors the port range table and predicts the response of every request.
    class range_table_tracker;
        int unsigned first_port [Slots];
        int unsigned end_port [Slots];
        int unsigned used;
        int unsigned base_reg;
        int unsigned limit_reg;
        int unsigned top_reg;
        status_t     want_status [$];
        logic [15:0] want_port [$];
        int unsigned errors;

        function new();
            used = 0;
            base_reg = 1024;
            limit_reg = 4096;
            top_reg = 65536;
            errors = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [16:0] value);
            case (idx)
                CFG_SEARCH_BASE:  base_reg = value[15:0];
                CFG_SEARCH_LIMIT: limit_reg = value;
                CFG_SPACE_TOP:    top_reg = value;
                default: ;
            endcase
        endfunction

        function int unsigned clip(int unsigned v);
            return (v > 65536) ? 65536 : v;
        endfunction

        function int unsigned align_up(int unsigned v, int unsigned a);
            if (a == 0)
                return v;
            return ((v + a - 1) / a) * a;
        endfunction

        function void expect_rsp(status_t st, int unsigned gp);
            want_status.push_back(st);
            want_port.push_back(gp[15:0]);
        endfunction

        function void place(int unsigned pos, int unsigned start, int unsigned size);
            if (used >= Slots) begin
                expect_rsp(ST_FULL, start);
                return;
            end
            for (int unsigned k = used; k > pos; k--) begin
                first_port[k] = first_port[k-1];
                end_port[k] = end_port[k-1];
            end
            first_port[pos] = start & 16'hFFFF;
            end_port[pos] = (start + size) & 17'h1FFFF;
            used++;
            expect_rsp(ST_DONE, start);
        endfunction

        function void note_request(logic [1:0] kind, logic [15:0] port,
                                   logic [16:0] size, logic [12:0] align);
            int unsigned p;
            int unsigned s;
            int unsigned a;
            int unsigned i;
            int unsigned cand;
            p = port;
            s = size;
            a = align;
            case (kind_t'(kind))
                KIND_FIXED:
                begin
                    if (p + s > clip(top_reg)) begin
                        expect_rsp(ST_REFUSED, 0);
                        return;
                    end
                    for (i = 0; i < used; i++) begin
                        if (end_port[i] <= p)
                            continue;
                        if (first_port[i] >= p + s)
                            break;
                        expect_rsp(ST_REFUSED, 0);
                        return;
                    end
                    place(i, p, s);
                end
                KIND_ANY:
                begin
                    cand = align_up(base_reg, a);
                    for (i = 0; i < used; i++) begin
                        // Ranges below the search base only push the candidate up.
                        if (first_port[i] < base_reg) begin
                            if (end_port[i] > cand)
                                cand = align_up(end_port[i], a);
                            continue;
                        end
                        if (first_port[i] > cand && first_port[i] - cand > s)
                            break;
                        cand = align_up(end_port[i], a);
                    end
                    if (cand >= 65536 || cand + s > clip(limit_reg))
                        expect_rsp(ST_REFUSED, 0);
                    else
                        place(i, cand, s);
                end
                KIND_FREE:
                begin
                    for (i = 0; i < used; i++) begin
                        if (first_port[i] == p) begin
                            for (int unsigned j = i; j + 1 < used; j++) begin
                                first_port[j] = first_port[j+1];
                                end_port[j] = end_port[j+1];
                            end
                            used--;
                            expect_rsp(ST_DONE, p);
                            return;
                        end
                        if (first_port[i] > p)
                            break;
                    end
                    expect_rsp(ST_REFUSED, 0);
                end
                default: expect_rsp(ST_REFUSED, 0);
            endcase
        endfunction

        function void check_rsp(logic [1:0] st, logic [15:0] gp);
            status_t es;
            logic [15:0] ep;
            if (want_status.size() == 0) begin
                $display("%0t: response with none pending: status %0d port %0d",
                         $time, st, gp);
                errors++;
                return;
            end
            es = want_status.pop_front();
            ep = want_port.pop_front();
            if (st !== es) begin
                $display("%0t: status expected %0d actual %0d", $time, es, st);
                errors++;
            end
            if (gp !== ep) begin
                $display("%0t: granted_port expected %0d actual %0d", $time, ep, gp);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return want_status.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [16:0] cfg_data;
    bit no_idle;
    bit long_hold;
    longint cycles;

    iopra_req_if req ();
    iopra_rsp_if rsp ();
    range_table_tracker tracker;

    io_port_range_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Response side: random stalls, plus one long hold-off on request.
    initial
    begin
        int unsigned stall;
        rsp.ready = 1'b0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold) begin
                rsp.ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end else if (stall > 0) begin
                rsp.ready <= 1'b0;
                stall--;
            end else begin
                rsp.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            tracker.note_request(req.kind, req.port, req.size, req.align);
        if (rst_n && rsp.valid && rsp.ready)
            tracker.check_rsp(rsp.status, rsp.granted_port);
    end

    task automatic send_request(kind_t kind, logic [15:0] port, logic [16:0] size,
                                logic [12:0] align);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.kind <= kind;
        req.port <= port;
        req.size <= size;
        req.align <= align;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [16:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.write_reg(idx, value);
    endtask

    function automatic logic [16:0] rand_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 64);
        if (r < 90)
            return $urandom_range(0, 4096);
        if (r < 98)
            return $urandom_range(0, 65536);
        return 17'h10000;
    endfunction

    function automatic logic [12:0] rand_align();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 0;
        if (r < 7)
            return 13'd1 << $urandom_range(0, 12);
        return $urandom_range(0, 4096);
    endfunction

    task automatic random_phase(int unsigned count, int unsigned alloc_pct);
        int unsigned r;
        logic [15:0] port;
        for (int unsigned n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_request(KIND_BAD, $urandom_range(0, 65535), rand_size(), rand_align());
            end else if (r < 3 + alloc_pct / 2) begin
                port = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 8191);
                send_request(KIND_FIXED, port, rand_size(), rand_align());
            end else if (r < 3 + alloc_pct) begin
                send_request(KIND_ANY, $urandom_range(0, 65535), rand_size(), rand_align());
            end else begin
                // Mostly free a range that is in the table now.
                if (tracker.used > 0 && $urandom_range(0, 4) != 0)
                    port = tracker.first_port[$urandom_range(0, tracker.used - 1)];
                else
                    port = $urandom_range(0, 65535);
                send_request(KIND_FREE, port, rand_size(), rand_align());
            end
        end
        drain();
    endtask

    initial
    begin
        tracker = new();
        no_idle = 1'b0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SEARCH_BASE;
        cfg_data = '0;
        req.valid = 1'b0;
        req.kind = KIND_FIXED;
        req.port = '0;
        req.size = '0;
        req.align = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset register values.
        send_request(KIND_FIXED, 16'd0, 17'd0, 13'd0);
        send_request(KIND_FIXED, 16'hFFFF, 17'd1, 13'd0);
        send_request(KIND_FIXED, 16'hFFFF, 17'd2, 13'd0);
        send_request(KIND_FIXED, 16'd1000, 17'd100, 13'd0);
        send_request(KIND_FIXED, 16'd1050, 17'd10, 13'd0);
        send_request(KIND_ANY, 16'd0, 17'd16, 13'd0);
        send_request(KIND_ANY, 16'd0, 17'd16, 13'd4096);
        send_request(KIND_ANY, 16'd0, 17'd5, 13'd3);
        send_request(KIND_ANY, 16'd0, 17'h10000, 13'd0);
        send_request(KIND_ANY, 16'd0, 17'd0, 13'd7);
        send_request(KIND_FIXED, 16'd2000, 17'd0, 13'h1FFF);
        send_request(KIND_FREE, 16'd1000, 17'd0, 13'd0);
        send_request(KIND_FREE, 16'd1234, 17'd0, 13'd0);
        send_request(KIND_FREE, 16'd2000, 17'd0, 13'd0);
        send_request(KIND_BAD, 16'hFFFF, 17'h1FFFF, 13'h1FFF);
        send_request(KIND_ANY, 16'd0, 17'd3000, 13'd1);
        send_request(KIND_FREE, 16'hFFFF, 17'd0, 13'd0);
        drain();

        write_reg(CFG_SEARCH_BASE, 17'd0);
        write_reg(CFG_SEARCH_LIMIT, 17'h10000);
        write_reg(CFG_SPACE_TOP, 17'h10000);
        no_idle = 1'b1;
        random_phase(220, 80);
        no_idle = 1'b0;

        // The response side holds off while requests keep coming.
        long_hold = 1'b1;
        random_phase(220, 60);

        write_reg(CFG_SEARCH_BASE, 17'hFFFF);
        write_reg(CFG_SPACE_TOP, 17'd1);
        random_phase(150, 70);

        write_reg(CFG_SEARCH_BASE, 17'd1024);
        write_reg(CFG_SEARCH_LIMIT, 17'd0);
        write_reg(CFG_SPACE_TOP, 17'h1FFFF);
        random_phase(150, 60);

        write_reg(CFG_SEARCH_LIMIT, 17'h1FFFF);
        random_phase(250, 75);

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_SEARCH_BASE, $urandom_range(0, 65535));
            write_reg(CFG_SEARCH_LIMIT, $urandom_range(0, 131071));
            write_reg(CFG_SPACE_TOP, $urandom_range(1, 131071));
            random_phase(150, 65);
        end

        write_reg(CFG_SEARCH_BASE, 17'd1024);
        write_reg(CFG_SEARCH_LIMIT, 17'd4096);
        write_reg(CFG_SPACE_TOP, 17'h10000);
        random_phase(300, 60);

        if (tracker.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
